[src/awmd_pkg.sv]
// shared types, constants and helpers for the alpha-weighted mip downsampler
package awmd_pkg;

	localparam logic [12:0] MAX_WIDTH   = 13'd4096;
	localparam logic [14:0] MAX_HEIGHT  = 15'd16384;
	localparam int          STORE_DEPTH = 4096 / 2;
	localparam int          FIFO_DEPTH  = 4;
	localparam int          DIV_STEPS   = 8;

	localparam logic CFG_SRC_WIDTH  = 1'b0;
	localparam logic CFG_SRC_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       level_done;
	} pixel_out_t;

	// sums of two pixels (also used for one pixel)
	typedef struct packed {
		logic [8:0]  a;
		logic [16:0] r;
		logic [16:0] g;
		logic [16:0] b;
	} pair_t;

	// sums of four pixels plus end-of-level flag
	typedef struct packed {
		logic [9:0]  a;
		logic [17:0] r;
		logic [17:0] g;
		logic [17:0] b;
		logic        last;
	} total_t;

	typedef struct packed {
		logic        col_store;
		logic        row_store;
		logic        total;
		logic        w1;
		logic        h1;
		logic        last;
		logic [10:0] x;
	} front_ctl_t;

	// restoring divider state: partial remainder and numerator/quotient bits
	typedef struct packed {
		logic [9:0] rem;
		logic [7:0] bits;
	} div_t;

	function automatic div_t div_step(div_t d, logic [9:0] a);
		logic [10:0] t;
		logic        ge;
		logic [10:0] n;
		div_t        o;
		t = {d.rem, d.bits[7]};
		ge = (t >= {1'b0, a});
		n = ge ? (t - {1'b0, a}) : t;
		o.rem = n[9:0];
		o.bits = {d.bits[6:0], ge};
		return o;
	endfunction

endpackage

[src/awmd_front.sv]
// front end: counters, products, column pair and line store, four-pixel sums
module awmd_front import awmd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [14:0] cfg_data,
	input  logic       src_valid,
	output logic       src_stall,
	input  pixel_in_t  src_pixel,
	output logic       push,
	output total_t     push_data,
	input  logic       fifo_full
);

	logic [12:0] width_q;
	logic [14:0] height_q;
	logic [11:0] col_q;
	logic [13:0] row_q;
	logic [12:0] w_eff;
	logic [14:0] h_eff;
	logic        w1, h1;
	logic [12:0] c_nxt;
	logic [14:0] r_nxt;
	logic        col_wrap, row_wrap;
	logic [10:0] x;
	logic [12:0] y;
	logic [11:0] out_w;
	logic [13:0] out_h;
	logic        have_pair;
	front_ctl_t  ctl;
	logic        en, accept;

	logic        v_s1;
	pixel_in_t   pix_s1;
	front_ctl_t  ctl_s1;
	logic        v_s2;
	front_ctl_t  ctl_s2;
	logic [7:0]  a_s2;
	logic [15:0] r_s2, g_s2, b_s2;
	pair_t       rd_s2;
	pair_t       colsum_q;
	pair_t       px, pair;
	logic        wr;
	pair_t       mem [STORE_DEPTH];

	always_comb begin
		w_eff = (width_q == 13'd0) ? 13'd1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
		h_eff = (height_q == 15'd0) ? 15'd1 : ((height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q);
		w1 = (w_eff == 13'd1);
		h1 = (h_eff == 15'd1);
		c_nxt = {1'b0, col_q} + 13'd1;
		r_nxt = {1'b0, row_q} + 15'd1;
		col_wrap = (c_nxt >= w_eff);
		row_wrap = (r_nxt >= h_eff);
		x = w1 ? 11'd0 : col_q[11:1];
		y = h1 ? 13'd0 : row_q[13:1];
		out_w = w1 ? 12'd1 : w_eff[12:1];
		out_h = h1 ? 14'd1 : h_eff[14:1];
		have_pair = w1 || col_q[0];
		ctl.col_store = !w1 && !col_q[0] && !col_wrap;
		ctl.row_store = have_pair && !h1 && !row_q[0] && !row_wrap;
		ctl.total = have_pair && (h1 || row_q[0]);
		ctl.w1 = w1;
		ctl.h1 = h1;
		ctl.last = (({1'b0, x} + 12'd1) == out_w) && (({1'b0, y} + 14'd1) == out_h);
		ctl.x = x;
	end

	// whole front advances unless a finished sum cannot enter the queue
	assign en = !(v_s2 && ctl_s2.total && fifo_full);
	assign src_stall = !en;
	assign accept = src_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd1;
			height_q <= 15'd1;
			col_q <= 12'd0;
			row_q <= 14'd0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SRC_WIDTH) begin
				width_q <= cfg_data[12:0];
			end else begin
				height_q <= cfg_data;
			end
			col_q <= 12'd0;
			row_q <= 14'd0;
		end else if (accept) begin
			col_q <= col_wrap ? 12'd0 : c_nxt[11:0];
			if (col_wrap) begin
				row_q <= row_wrap ? 14'd0 : r_nxt[13:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= src_pixel;
			ctl_s1 <= ctl;
		end
		if (en) begin
			ctl_s2 <= ctl_s1;
			a_s2 <= pix_s1.in_alpha;
			r_s2 <= pix_s1.in_red * pix_s1.in_alpha;
			g_s2 <= pix_s1.in_green * pix_s1.in_alpha;
			b_s2 <= pix_s1.in_blue * pix_s1.in_alpha;
		end
	end

	always_comb begin
		px.a = {1'b0, a_s2};
		px.r = {1'b0, r_s2};
		px.g = {1'b0, g_s2};
		px.b = {1'b0, b_s2};
		if (ctl_s2.w1) begin
			pair.a = px.a + px.a;
			pair.r = px.r + px.r;
			pair.g = px.g + px.g;
			pair.b = px.b + px.b;
		end else begin
			pair.a = colsum_q.a + px.a;
			pair.r = colsum_q.r + px.r;
			pair.g = colsum_q.g + px.g;
			pair.b = colsum_q.b + px.b;
		end
		if (ctl_s2.h1) begin
			push_data.a = {1'b0, pair.a} + {1'b0, pair.a};
			push_data.r = {1'b0, pair.r} + {1'b0, pair.r};
			push_data.g = {1'b0, pair.g} + {1'b0, pair.g};
			push_data.b = {1'b0, pair.b} + {1'b0, pair.b};
		end else begin
			push_data.a = {1'b0, rd_s2.a} + {1'b0, pair.a};
			push_data.r = {1'b0, rd_s2.r} + {1'b0, pair.r};
			push_data.g = {1'b0, rd_s2.g} + {1'b0, pair.g};
			push_data.b = {1'b0, rd_s2.b} + {1'b0, pair.b};
		end
		push_data.last = ctl_s2.last;
	end

	assign push = v_s2 && ctl_s2.total && !fifo_full;
	assign wr = en && v_s2 && ctl_s2.row_store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colsum_q <= '0;
		end else if (cfg_we) begin
			colsum_q <= '0;
		end else if (en && v_s2 && ctl_s2.col_store) begin
			colsum_q <= px;
		end
	end

	// line store; bypass covers a write and read of one entry at the same edge
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[ctl_s2.x] <= pair;
		end
		if (en && v_s1) begin
			rd_s2 <= (wr && (ctl_s2.x == ctl_s1.x)) ? pair : mem[ctl_s1.x];
		end
	end

endmodule

[src/awmd_fifo.sv]
// short queue of four-pixel sums between front and back
module awmd_fifo import awmd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  total_t push_data,
	output logic   full,
	input  logic   pop,
	output total_t pop_data,
	output logic   empty
);

	total_t     mem [FIFO_DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full = (cnt_q == 3'(FIFO_DEPTH));
	assign empty = (cnt_q == 3'd0);
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 2'd0;
			rd_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

endmodule

[src/awmd_back.sv]
// back end: pipelined restoring dividers for the weighted colors, output register
module awmd_back import awmd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  total_t     pop_data,
	output logic       pop,
	output logic       dst_valid,
	input  logic       dst_stall,
	output pixel_out_t dst_pixel
);

	logic        vld_s [DIV_STEPS+1];
	logic [9:0]  a_s   [DIV_STEPS+1];
	logic        last_s [DIV_STEPS+1];
	div_t        red_s [DIV_STEPS+1];
	div_t        grn_s [DIV_STEPS+1];
	div_t        blu_s [DIV_STEPS+1];
	logic        dst_valid_q;
	pixel_out_t  dst_pixel_q;
	logic        en;
	logic [17:0] half;
	logic [17:0] nr, ng, nb;
	logic [9:0]  a_rnd;
	logic        az;

	assign en = !(dst_valid_q && dst_stall);
	assign pop = !empty && en;
	assign dst_valid = dst_valid_q;
	assign dst_pixel = dst_pixel_q;

	always_comb begin
		half = {9'd0, pop_data.a[9:1]};
		nr = pop_data.r + half;
		ng = pop_data.g + half;
		nb = pop_data.b + half;
		a_rnd = a_s[DIV_STEPS] + 10'd2;
		az = (a_s[DIV_STEPS] == 10'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) begin
				vld_s[k] <= 1'b0;
			end
			dst_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pop;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			dst_valid_q <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0] <= pop_data.a;
			last_s[0] <= pop_data.last;
			red_s[0] <= '{rem: nr[17:8], bits: nr[7:0]};
			grn_s[0] <= '{rem: ng[17:8], bits: ng[7:0]};
			blu_s[0] <= '{rem: nb[17:8], bits: nb[7:0]};
			for (int k = 1; k <= DIV_STEPS; k++) begin
				a_s[k] <= a_s[k-1];
				last_s[k] <= last_s[k-1];
				red_s[k] <= div_step(red_s[k-1], a_s[k-1]);
				grn_s[k] <= div_step(grn_s[k-1], a_s[k-1]);
				blu_s[k] <= div_step(blu_s[k-1], a_s[k-1]);
			end
			dst_pixel_q.out_red <= az ? 8'd0 : red_s[DIV_STEPS].bits;
			dst_pixel_q.out_green <= az ? 8'd0 : grn_s[DIV_STEPS].bits;
			dst_pixel_q.out_blue <= az ? 8'd0 : blu_s[DIV_STEPS].bits;
			dst_pixel_q.out_alpha <= a_rnd[9:2];
			dst_pixel_q.level_done <= last_s[DIV_STEPS];
		end
	end

endmodule

[src/alpha_weighted_mip_downsampler.sv]
// top level of the alpha-weighted 2x2 mip downsampler
// a beat completing a 2x2 block goes through the front stages, queue, divider steps and result register
// throughput: one source pixel per cycle while src_stall is low, up to one result per cycle (single row and column)
// the front pipeline (two stages around the line store port) sets the input rate
// reset clears counters, queue and valid bits; size registers come up as 1x1
// the line store needs no clearing pass, every entry is written before it is read
module alpha_weighted_mip_downsampler import awmd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [14:0] cfg_data,
	input  logic       src_valid,
	output logic       src_stall,
	input  pixel_in_t  src_pixel,
	output logic       dst_valid,
	input  logic       dst_stall,
	output pixel_out_t dst_pixel
);

	// four-pixel sums from the front into the queue
	logic   push;
	total_t push_data;
	logic   fifo_full;
	// queue toward the divider pipeline
	logic   pop;
	total_t pop_data;
	logic   fifo_empty;

	// front: counts columns and rows, forms pair sums, keeps the even row in the line store
	awmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_pixel (src_pixel),
		.push      (push),
		.push_data (push_data),
		.fifo_full (fifo_full)
	);

	// queue lets the divider stall without holding the source side at once
	awmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (fifo_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (fifo_empty)
	);

	// back: eight-step divider pipeline per color, then the result register
	awmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (fifo_empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_pixel (dst_pixel)
	);

	// the front must hold a finished sum rather than push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("push into full queue");

	// the back pulls only when the queue holds a beat
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_empty)
		else $error("pop from empty queue");

	// a stalled result beat holds back the whole divider, so no pop happens
	a_stall_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_stall) |-> !pop)
		else $error("pop while result stalled");

endmodule

[test/alpha_weighted_mip_downsampler_checker.sv]
// checker for the mip downsampler: predicts filtered pixels and compares result beats
module alpha_weighted_mip_downsampler_checker import awmd_pkg::*; (
	input  logic       clk,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [14:0] cfg_data,
	input  logic       src_valid,
	input  logic       src_stall,
	input  pixel_in_t  src_pixel,
	input  logic       dst_valid,
	input  logic       dst_stall,
	input  pixel_out_t dst_pixel,
	output int         fail_count,
	output int         pending,
	output int         result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		int a;
		int r;
		int g;
		int b;
	} wsum_t;

	int unsigned width_reg = 1, height_reg = 1;
	int unsigned col = 0, row = 0;
	wsum_t col_pair;
	wsum_t line_sums [STORE_DEPTH];
	pixel_out_t filtered_q[$];

	function automatic logic [7:0] wmean(int c, int a);
		if (a == 0)
			return 8'd0;
		return 8'((c + a / 2) / a);
	endfunction

	function automatic wsum_t add2(wsum_t x, wsum_t y);
		wsum_t s;
		s.a = x.a + y.a;
		s.r = x.r + y.r;
		s.g = x.g + y.g;
		s.b = x.b + y.b;
		return s;
	endfunction

	task automatic filter_pixel(pixel_in_t p);
		int unsigned w, h, ow, oh, x, y;
		wsum_t px, pair, tot;
		bit has_pair, has_tot;
		pixel_out_t o;
		w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		ow = (w > 1) ? w / 2 : 1;
		oh = (h > 1) ? h / 2 : 1;
		has_pair = 0;
		has_tot = 0;
		x = 0;
		y = 0;
		px.a = p.in_alpha;
		px.r = p.in_red * p.in_alpha;
		px.g = p.in_green * p.in_alpha;
		px.b = p.in_blue * p.in_alpha;
		if (w == 1) begin
			pair = add2(px, px);
			has_pair = 1;
		end else if (!col[0]) begin
			if (col + 1 < w)
				col_pair = px;
		end else begin
			pair = add2(col_pair, px);
			has_pair = 1;
			x = col / 2;
		end
		if (has_pair) begin
			if (h == 1) begin
				tot = add2(pair, pair);
				has_tot = 1;
			end else if (!row[0]) begin
				if (row + 1 < h)
					line_sums[x] = pair;
			end else begin
				tot = add2(line_sums[x], pair);
				has_tot = 1;
				y = row / 2;
			end
		end
		if (has_tot) begin
			o.out_red = wmean(tot.r, tot.a);
			o.out_green = wmean(tot.g, tot.a);
			o.out_blue = wmean(tot.b, tot.a);
			o.out_alpha = 8'((tot.a + 2) / 4);
			o.level_done = (x + 1 == ow) && (y + 1 == oh);
			filtered_q.push_back(o);
		end
		col++;
		if (col >= w) begin
			col = 0;
			row++;
			if (row >= h)
				row = 0;
		end
	endtask

	initial begin
		fail_count = 0;
		result_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		pixel_out_t e;
		if (cfg_we) begin
			if (cfg_index == CFG_SRC_WIDTH)
				width_reg = cfg_data[12:0];
			else
				height_reg = cfg_data;
			col = 0;
			row = 0;
			col_pair = '{0, 0, 0, 0};
		end
		if (src_valid && !src_stall)
			filter_pixel(src_pixel);
		if (dst_valid && !dst_stall) begin
			result_count++;
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, dst_pixel);
				fail_count++;
			end else begin
				e = filtered_q.pop_front();
				if (e !== dst_pixel) begin
					$display("%0t: expected %p actual %p", $time, e, dst_pixel);
					fail_count++;
				end
			end
		end
		pending = filtered_q.size();
	end
endmodule

[test/alpha_weighted_mip_downsampler_tb.sv]
// testbench top: drives sizes, pixel beats and result stalls, gives the verdict
module alpha_weighted_mip_downsampler_tb import awmd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_we = 0;
	logic       cfg_index = CFG_SRC_WIDTH;
	logic [14:0] cfg_data = '0;
	logic       src_valid = 0;
	logic       src_stall;
	pixel_in_t  src_pixel = '0;
	logic       dst_valid;
	logic       dst_stall = 0;
	pixel_out_t dst_pixel;
	int         fail_count, pending, result_count;
	int         beats_sent = 0;
	int         hold_off = 0;   // cycles of forced receiver stall left
	bit         stalls_on = 1;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	alpha_weighted_mip_downsampler i_dut (.*);

	alpha_weighted_mip_downsampler_checker i_chk (.*);

	// random gap length: mostly short, sometimes long
	function automatic int gap_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 8);
		if ($urandom_range(2) == 0)
			return 0;
		return $urandom_range(3);
	endfunction

	// receiver side stall pattern, plus long hold-off when asked
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				dst_stall <= 1;
				hold_off--;
			end else if (!stalls_on) begin
				dst_stall <= 0;
			end else begin
				n = gap_len();
				if (n == 0)
					dst_stall <= 0;
				else begin
					dst_stall <= 1;
					repeat (n - 1) begin
						@(negedge clk);
						if (hold_off > 0) hold_off--;
					end
				end
			end
		end
	end

	// one pixel beat; valid stays high if another beat follows with no gap
	task automatic send_pixel(pixel_in_t p, int gap);
		src_valid <= 1;
		src_pixel <= p;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		beats_sent++;
		@(negedge clk);
		if (gap > 0) begin
			src_valid <= 0;
			src_pixel <= pixel_in_t'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic rand_pixel(output pixel_in_t p);
		int k;
		p = pixel_in_t'($urandom);
		k = $urandom_range(7);
		// bias alpha toward the zero and full extremes
		if (k == 0) p.in_alpha = 0;
		if (k == 1) p.in_alpha = 8'hff;
	endtask

	// close the source side, wait out all outstanding results, then the block's own latency
	task automatic drain();
		src_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic set_size(int unsigned w, int unsigned h);
		drain();
		cfg_we <= 1;
		cfg_index <= CFG_SRC_WIDTH;
		cfg_data <= 15'(w);
		@(negedge clk);
		cfg_index <= CFG_SRC_HEIGHT;
		cfg_data <= 15'(h);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// one whole frame of random pixels
	task automatic send_frame(int unsigned w, int unsigned h, bit dense);
		pixel_in_t p;
		repeat (w * h) begin
			rand_pixel(p);
			send_pixel(p, dense ? 0 : gap_len());
		end
	endtask

	initial begin
		pixel_in_t p;
		int unsigned w, h;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: default 1x1 size, extreme pixels and zero alpha
		send_pixel('{8'hff, 8'hff, 8'hff, 8'hff}, 1);
		send_pixel('{8'h00, 8'h00, 8'h00, 8'h00}, 0);
		send_pixel('{8'hff, 8'h00, 8'h80, 8'h01}, 2);
		// odd sizes drop last row and column, single column and row duplicate
		set_size(3, 3);
		for (int i = 0; i < 9; i++)
			send_pixel('{8'(i * 31), 8'hff, 8'h00, 8'(i * 40)}, 0);
		set_size(1, 4);
		send_frame(1, 4, 0);
		set_size(4, 1);
		send_frame(4, 1, 1);
		// zero and oversize values clamp
		set_size(0, 0);
		send_frame(1, 1, 0);
		set_size(15'h1fff, 15'h7fff);
		send_frame(4, 1, 0);

		// long receiver hold-off while the sender keeps offering, enough results to fill up
		set_size(8, 16);
		hold_off = 200;
		send_frame(8, 16, 1);
		drain();

		// a wide frame of two rows with no receiver stalls
		set_size(256, 2);
		stalls_on = 0;
		send_frame(256, 2, 1);
		stalls_on = 1;

		// random sizes, mostly small, two frames each so wrap is covered
		while (beats_sent < 900) begin
			w = $urandom_range(8, 1);
			h = $urandom_range(8, 1);
			if ($urandom_range(7) == 0) w = $urandom_range(40, 9);
			set_size(w, h);
			send_frame(w, h, $urandom_range(3) == 0);
			send_frame(w, h, 0);
		end
		drain();

		$display("%0d pixel beats sent, %0d filtered results checked over many frame sizes",
			beats_sent, result_count);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
